>>> hdl/kbs_pkg.sv
package kbs_pkg;

  localparam int SYMBOLS = 256;
  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = $clog2(SYMBOLS);
  localparam int POS_W   = ADDR_W + 1;

  typedef logic [1:0]        cmd_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [POS_W-1:0]  pos_t;

  localparam cmd_t CMD_KEY = 2'd0;
  localparam cmd_t CMD_ENC = 2'd1;
  localparam cmd_t CMD_DEC = 2'd2;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_KEY = 1'b1;

  // sweep bounds
  localparam pos_t POS_LAST = pos_t'(SYMBOLS - 1);
  localparam pos_t POS_END  = pos_t'(SYMBOLS);

endpackage

>>> hdl/kbs_ram.sv
module kbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/keyword_byte_substitution.sv
// Data beats (encrypt/decrypt): one per cycle sustained while out_ready is high and no key is
//   loading; out_valid rises once the table read from the accepting edge moves into the output
//   register, which it does only when that is free or being drained. Key beats: used-map read,
//   then append. The last one adds a fill sweep and an inverse-table sweep, one entry per cycle.
// Reset (rst_n low, synchronous): control state cleared, then a pass over all 256 entries zeroes
//   the used map while in_ready stays low. Table contents are undefined until a key is loaded.
module keyword_byte_substitution (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [7:0] in_value,
  input  logic       in_key_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_status
);

  // Sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;  // zero used map after reset
  localparam logic [2:0] S_IDLE = 3'd1;  // take beats
  localparam logic [2:0] S_KCHK = 3'd2;  // used-map data back, append key byte
  localparam logic [2:0] S_FILL = 3'd3;  // append unused bytes, clear used map behind
  localparam logic [2:0] S_INV  = 3'd4;  // build inverse table from forward table

  logic [2:0]     st_r, st_nxt;
  kbs_pkg::pos_t  cnt_r, cnt_nxt;
  kbs_pkg::pos_t  fill_r, fill_nxt;
  kbs_pkg::pos_t  cnt_m1;
  kbs_pkg::addr_t pidx;
  logic           key_ready_r, key_ready_nxt;
  logic           key_loading_r, key_loading_nxt;
  kbs_pkg::byte_t kval_r, kval_nxt;
  logic           klast_r, klast_nxt;

  // data beat whose table read is in flight / held in the RAM output register
  logic           pend_r, pend_nxt;
  logic           pend_fwd_r, pend_fwd_nxt;
  logic           pend_nokey_r, pend_nokey_nxt;

  logic           out_valid_r, out_valid_nxt;
  kbs_pkg::byte_t out_byte_r, out_byte_nxt;
  logic           out_status_r, out_status_nxt;

  // memory ports
  logic           used_we, used_re;
  kbs_pkg::addr_t used_waddr, used_raddr;
  logic [0:0]     used_wdata, used_rdata;
  logic           fwd_we, fwd_re;
  kbs_pkg::addr_t fwd_waddr, fwd_raddr;
  kbs_pkg::byte_t fwd_wdata, fwd_rdata;
  logic           inv_we, inv_re;
  kbs_pkg::addr_t inv_waddr, inv_raddr;
  kbs_pkg::byte_t inv_wdata, inv_rdata;

  logic advance, acc, is_key, is_data;

  kbs_ram #(.WIDTH(1), .DEPTH(kbs_pkg::SYMBOLS)) u_used (
    .clk(clk), .we(used_we), .waddr(used_waddr), .wdata(used_wdata),
    .re(used_re), .raddr(used_raddr), .rdata(used_rdata)
  );

  kbs_ram #(.WIDTH(kbs_pkg::BYTE_W), .DEPTH(kbs_pkg::SYMBOLS)) u_fwd (
    .clk(clk), .we(fwd_we), .waddr(fwd_waddr), .wdata(fwd_wdata),
    .re(fwd_re), .raddr(fwd_raddr), .rdata(fwd_rdata)
  );

  kbs_ram #(.WIDTH(kbs_pkg::BYTE_W), .DEPTH(kbs_pkg::SYMBOLS)) u_inv (
    .clk(clk), .we(inv_we), .waddr(inv_waddr), .wdata(inv_wdata),
    .re(inv_re), .raddr(inv_raddr), .rdata(inv_rdata)
  );

  // Pending beat moves to the output register when that is free or being drained.
  // Input is held off while a pending beat is stuck, so its RAM read data stays put.
  assign advance  = pend_r && (!out_valid_r || out_ready);
  assign in_ready = (st_r == S_IDLE) && (!pend_r || advance);
  assign acc      = in_valid && in_ready;
  assign is_key   = (in_command == kbs_pkg::CMD_KEY);
  assign is_data  = (in_command == kbs_pkg::CMD_ENC) || (in_command == kbs_pkg::CMD_DEC);

  // sweep entry processed this cycle (its read was issued in the previous cycle)
  assign cnt_m1 = cnt_r - 1'b1;
  assign pidx   = cnt_m1[kbs_pkg::ADDR_W-1:0];

  always_comb begin
    st_nxt          = st_r;
    cnt_nxt         = cnt_r;
    fill_nxt        = fill_r;
    key_ready_nxt   = key_ready_r;
    key_loading_nxt = key_loading_r;
    kval_nxt        = kval_r;
    klast_nxt       = klast_r;

    used_we    = 1'b0;
    used_waddr = kval_r;
    used_wdata = 1'b0;
    used_re    = 1'b0;
    used_raddr = in_value;
    fwd_we     = 1'b0;
    fwd_waddr  = fill_r[kbs_pkg::ADDR_W-1:0];
    fwd_wdata  = kval_r;
    fwd_re     = 1'b0;
    fwd_raddr  = in_value;
    inv_we     = 1'b0;
    inv_waddr  = fwd_rdata;
    inv_wdata  = pidx;
    inv_re     = 1'b0;
    inv_raddr  = in_value;

    unique case (st_r)
      S_CLR: begin
        used_we    = 1'b1;
        used_waddr = cnt_r[kbs_pkg::ADDR_W-1:0];
        used_wdata = 1'b0;
        if (cnt_r == kbs_pkg::POS_LAST) begin
          st_nxt  = S_IDLE;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (acc && is_key) begin
          // first beat of a key withdraws the old one
          if (!key_loading_r) begin
            fill_nxt        = '0;
            key_ready_nxt   = 1'b0;
            key_loading_nxt = 1'b1;
          end
          used_re    = 1'b1;
          used_raddr = in_value;
          kval_nxt   = in_value;
          klast_nxt  = in_key_last;
          st_nxt     = S_KCHK;
        end else if (acc && is_data && key_ready_r) begin
          fwd_re    = (in_command == kbs_pkg::CMD_ENC);
          fwd_raddr = in_value;
          inv_re    = (in_command == kbs_pkg::CMD_DEC);
          inv_raddr = in_value;
        end
      end
      S_KCHK: begin
        if (!used_rdata[0] && (fill_r < kbs_pkg::POS_END)) begin
          used_we    = 1'b1;
          used_waddr = kval_r;
          used_wdata = 1'b1;
          fwd_we     = 1'b1;
          fwd_waddr  = fill_r[kbs_pkg::ADDR_W-1:0];
          fwd_wdata  = kval_r;
          fill_nxt   = fill_r + 1'b1;
        end
        if (klast_r) begin
          st_nxt  = S_FILL;
          cnt_nxt = '0;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_FILL: begin
        if (cnt_r != kbs_pkg::POS_END) begin
          used_re    = 1'b1;
          used_raddr = cnt_r[kbs_pkg::ADDR_W-1:0];
        end
        if (cnt_r != '0) begin
          // clear behind the sweep so the map is blank for the next key
          used_we    = 1'b1;
          used_waddr = pidx;
          used_wdata = 1'b0;
          if (!used_rdata[0] && (fill_r < kbs_pkg::POS_END)) begin
            fwd_we    = 1'b1;
            fwd_waddr = fill_r[kbs_pkg::ADDR_W-1:0];
            fwd_wdata = pidx;
            fill_nxt  = fill_r + 1'b1;
          end
        end
        if (cnt_r == kbs_pkg::POS_END) begin
          st_nxt  = S_INV;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_INV: begin
        if (cnt_r != kbs_pkg::POS_END) begin
          fwd_re    = 1'b1;
          fwd_raddr = cnt_r[kbs_pkg::ADDR_W-1:0];
        end
        if (cnt_r != '0) begin
          inv_we    = 1'b1;
          inv_waddr = fwd_rdata;
          inv_wdata = pidx;
        end
        if (cnt_r == kbs_pkg::POS_END) begin
          st_nxt          = S_IDLE;
          cnt_nxt         = '0;
          key_ready_nxt   = 1'b1;
          key_loading_nxt = 1'b0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // data beat pipeline: read stage, then output register
  always_comb begin
    pend_nxt       = pend_r && !advance;
    pend_fwd_nxt   = pend_fwd_r;
    pend_nokey_nxt = pend_nokey_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;

    if (acc && is_data) begin
      pend_nxt       = 1'b1;
      pend_fwd_nxt   = (in_command == kbs_pkg::CMD_ENC);
      pend_nokey_nxt = !key_ready_r;
    end

    if (advance) begin
      out_valid_nxt = 1'b1;
      if (pend_nokey_r) begin
        out_byte_nxt   = '0;
        out_status_nxt = kbs_pkg::STATUS_NO_KEY;
      end else begin
        out_byte_nxt   = pend_fwd_r ? fwd_rdata : inv_rdata;
        out_status_nxt = kbs_pkg::STATUS_OK;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= S_CLR;
      cnt_r         <= '0;
      fill_r        <= '0;
      key_ready_r   <= 1'b0;
      key_loading_r <= 1'b0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      st_r          <= st_nxt;
      cnt_r         <= cnt_nxt;
      fill_r        <= fill_nxt;
      key_ready_r   <= key_ready_nxt;
      key_loading_r <= key_loading_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kval_r       <= kval_nxt;
    klast_r      <= klast_nxt;
    pend_fwd_r   <= pend_fwd_nxt;
    pend_nokey_r <= pend_nokey_nxt;
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_status = out_status_r;

endmodule

>>> tb/tb_keyword_byte_substitution.sv
`timescale 1ns / 1ps

module tb_keyword_byte_substitution;

  // Command code that the block drops without a result.
  localparam kbs_pkg::cmd_t CMD_NONE = 2'd3;

  localparam int ITEMS      = 1600;  // rough stimulus size, not a quota
  localparam int IDLE_LIMIT = 4000;  // cycles with no beat on either side
  localparam int DRAIN      = 600;   // covers fill + inverse sweeps after a last key beat

  typedef struct packed {
    kbs_pkg::byte_t value;
    logic           status;
  } sub_result_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  kbs_pkg::cmd_t  in_command;
  kbs_pkg::byte_t in_value;
  logic           in_key_last;
  logic           out_valid;
  logic           out_ready;
  kbs_pkg::byte_t out_byte;
  logic           out_status;

  keyword_byte_substitution u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_value   (in_value),
    .in_key_last(in_key_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_status (out_status)
  );

  // ---------------------------------------------------------------------------
  // Cipher predictor: own copy of the key state, updated on every accepted
  // key beat. Results are queued in order of acceptance.
  // ---------------------------------------------------------------------------
  logic           key_seen [kbs_pkg::SYMBOLS];
  kbs_pkg::byte_t fwd_map  [kbs_pkg::SYMBOLS];
  kbs_pkg::byte_t inv_map  [kbs_pkg::SYMBOLS];
  kbs_pkg::pos_t  key_pos;
  logic           key_valid;
  logic           key_busy;

  sub_result_t expected_subs[$];

  int err_count    = 0;
  int items_sent   = 0;
  int keys_loaded  = 0;
  int longest_key  = 0;
  int enc_count    = 0;
  int dec_count    = 0;
  int no_key_count = 0;
  int subs_checked = 0;

  // Appends a byte to the forward table unless it is already in this key;
  // the position can never pass the end of the alphabet.
  function automatic void append_byte(kbs_pkg::byte_t b);
    if (!key_seen[b] && key_pos < kbs_pkg::POS_END) begin
      fwd_map[key_pos[kbs_pkg::ADDR_W-1:0]] = b;
      key_pos++;
      key_seen[b] = 1'b1;
    end
  endfunction

  function automatic void predict_beat(kbs_pkg::cmd_t c, kbs_pkg::byte_t v, logic last);
    sub_result_t r;
    case (c)
      kbs_pkg::CMD_KEY: begin
        // first beat of a key wipes the used map and withdraws the old key
        if (!key_busy) begin
          foreach (key_seen[i]) key_seen[i] = 1'b0;
          key_pos   = '0;
          key_valid = 1'b0;
          key_busy  = 1'b1;
        end
        append_byte(v);
        if (last) begin
          if (int'(key_pos) > longest_key) longest_key = int'(key_pos);
          // unused bytes in ascending order, then the inverse
          for (int s = 0; s < kbs_pkg::SYMBOLS; s++) append_byte(kbs_pkg::byte_t'(s));
          for (int s = 0; s < kbs_pkg::SYMBOLS; s++) inv_map[fwd_map[s]] = kbs_pkg::byte_t'(s);
          key_valid = 1'b1;
          key_busy  = 1'b0;
          keys_loaded++;
        end
      end
      kbs_pkg::CMD_ENC, kbs_pkg::CMD_DEC: begin
        if (!key_valid) begin
          r.value  = '0;
          r.status = kbs_pkg::STATUS_NO_KEY;
          no_key_count++;
        end else begin
          r.value  = (c == kbs_pkg::CMD_ENC) ? fwd_map[v] : inv_map[v];
          r.status = kbs_pkg::STATUS_OK;
        end
        if (c == kbs_pkg::CMD_ENC) enc_count++;
        else dec_count++;
        expected_subs.push_back(r);
      end
      default: ;  // unused command: no result, no state change
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps in between. Inputs move on
  // the falling edge only; gaps can be switched off for gap-free stretches.
  // ---------------------------------------------------------------------------
  int   burst_left = 0;
  logic gaps_on    = 1'b1;

  task automatic send_beat(kbs_pkg::cmd_t c, kbs_pkg::byte_t v, logic last);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gap = $urandom_range(1, 12);
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid    = 1'b1;
    in_command  = c;
    in_value    = v;
    in_key_last = last;
    do @(posedge clk); while (!in_ready);
    predict_beat(c, v, last);
    if (c != CMD_NONE) items_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern, changing mode after each span of random length.
  // Mode 0 never stalls, 1 is a coin toss, 2 a fixed repeating low-then-high rhythm,
  // 3 an occasional stall.
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    int span;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(64, 400);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        case (mode)
          0:       out_ready = 1'b1;
          1:       out_ready = 1'($urandom_range(0, 1));
          2:       out_ready = (i % 5) >= 2;
          default: out_ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each output beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sub_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_subs.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result beat: expected none, got byte %02h status %0b",
                 $time, out_byte, out_status);
      end else begin
        want = expected_subs.pop_front();
        subs_checked++;
        if (out_byte !== want.value) begin
          err_count++;
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $time, want.value, out_byte);
        end
        if (out_status !== want.status) begin
          err_count++;
          $display("%0t: out_status mismatch: expected %0b, actual %0b",
                   $time, want.status, out_status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any beat on either channel means a hang.
  // Covers the post-reset clearing pass and the fill sweeps with margin.
  // ---------------------------------------------------------------------------
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("%0t: no beat for %0d cycles, %0d results outstanding",
             $time, IDLE_LIMIT, expected_subs.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Data before any key: every data beat answers no_key; command 3 is dropped.
  task automatic test_no_key();
    send_beat(kbs_pkg::CMD_ENC, 8'h00, 1'b0);
    send_beat(kbs_pkg::CMD_DEC, 8'hFF, 1'b1);
    send_beat(CMD_NONE, 8'hFF, 1'b1);
    send_beat(kbs_pkg::CMD_ENC, 8'h80, 1'b0);
  endtask

  // One beat that both opens and closes the key.
  task automatic test_single_byte_key();
    send_beat(kbs_pkg::CMD_KEY, 8'hFF, 1'b1);
    send_beat(kbs_pkg::CMD_ENC, 8'h00, 1'b0);
    send_beat(kbs_pkg::CMD_ENC, 8'hFF, 1'b0);
    send_beat(kbs_pkg::CMD_DEC, 8'h00, 1'b0);
    send_beat(kbs_pkg::CMD_DEC, 8'hFF, 1'b0);
    send_beat(kbs_pkg::CMD_ENC, 8'h7F, 1'b1);  // key_last ignored on data
  endtask

  // Repeats within a key are skipped; command 3 mid-key leaves loading alone.
  task automatic test_repeated_key_bytes();
    send_beat(kbs_pkg::CMD_KEY, 8'h41, 1'b0);
    send_beat(kbs_pkg::CMD_KEY, 8'h41, 1'b0);
    send_beat(CMD_NONE, 8'h41, 1'b1);
    send_beat(kbs_pkg::CMD_KEY, 8'h00, 1'b0);
    send_beat(kbs_pkg::CMD_KEY, 8'h41, 1'b1);
    send_beat(kbs_pkg::CMD_ENC, 8'h00, 1'b0);
    send_beat(kbs_pkg::CMD_ENC, 8'h01, 1'b0);
    send_beat(kbs_pkg::CMD_ENC, 8'h41, 1'b0);
    send_beat(kbs_pkg::CMD_DEC, 8'h41, 1'b0);
    send_beat(kbs_pkg::CMD_DEC, 8'h00, 1'b0);
  endtask

  // A new key withdraws the old one at once; data while loading gets no_key.
  task automatic test_reload_mid_data();
    send_beat(kbs_pkg::CMD_KEY, 8'h10, 1'b0);
    send_beat(kbs_pkg::CMD_ENC, 8'h10, 1'b0);
    send_beat(kbs_pkg::CMD_DEC, 8'h10, 1'b1);
    send_beat(kbs_pkg::CMD_KEY, 8'h10, 1'b1);
    send_beat(kbs_pkg::CMD_ENC, 8'h10, 1'b0);
  endtask

  // Key naming all 256 bytes, then a repeat as last beat: table already full.
  task automatic test_full_alphabet_key();
    for (int s = kbs_pkg::SYMBOLS - 1; s >= 0; s--)
      send_beat(kbs_pkg::CMD_KEY, kbs_pkg::byte_t'(s), 1'b0);
    send_beat(kbs_pkg::CMD_KEY, 8'h55, 1'b1);
    for (int d = 0; d < 16; d++)
      send_beat((d % 2) ? kbs_pkg::CMD_DEC : kbs_pkg::CMD_ENC,
                kbs_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
  endtask

  // Mostly well-formed key-then-data phases with random content; some keys
  // left open, stray data inside keys and dropped commands as noise.
  task automatic test_random_traffic();
    int            klen;
    int            dlen;
    int            alpha;
    logic          close_key;
    kbs_pkg::cmd_t c;
    while (items_sent < ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 19))
        0:             klen = $urandom_range(200, 320);
        1, 2, 3, 4, 5: klen = $urandom_range(17, 64);
        default:       klen = $urandom_range(1, 16);
      endcase
      // narrow alphabet now and then, so repeats are common
      alpha     = ($urandom_range(0, 3) == 0) ? 7 : 255;
      close_key = ($urandom_range(0, 9) != 0);
      for (int k = 0; k < klen; k++) begin
        if ($urandom_range(0, 24) == 0)
          send_beat(CMD_NONE, kbs_pkg::byte_t'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        if ($urandom_range(0, 39) == 0)
          send_beat($urandom_range(0, 1) ? kbs_pkg::CMD_ENC : kbs_pkg::CMD_DEC,
                    kbs_pkg::byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_beat(kbs_pkg::CMD_KEY, kbs_pkg::byte_t'($urandom_range(0, alpha)),
                  close_key && (k == klen - 1));
      end
      dlen = $urandom_range(8, 60);
      for (int d = 0; d < dlen; d++) begin
        if ($urandom_range(0, 29) == 0) c = CMD_NONE;
        else c = $urandom_range(0, 1) ? kbs_pkg::CMD_ENC : kbs_pkg::CMD_DEC;
        send_beat(c, kbs_pkg::byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_command  = kbs_pkg::CMD_KEY;
    in_value    = '0;
    in_key_last = 1'b0;
    foreach (key_seen[i]) key_seen[i] = 1'b0;
    key_pos   = '0;
    key_valid = 1'b0;
    key_busy  = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_no_key();
    test_single_byte_key();
    test_repeated_key_bytes();
    test_reload_mid_data();
    test_full_alphabet_key();
    test_random_traffic();

    @(negedge clk);
    in_valid = 1'b0;

    // the watchdog bounds this wait
    while (expected_subs.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Run covered %0d keys (up to %0d key bytes placed before the fill), %s",
             keys_loaded, longest_key, $sformatf("%0d key and data beats", items_sent));
    $display("Checked %0d results: %0d encrypt, %0d decrypt, %0d answered without a key",
             subs_checked, enc_count, dec_count, no_key_count);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> keyword_byte_substitution.f
hdl/kbs_pkg.sv
hdl/kbs_ram.sv
hdl/keyword_byte_substitution.sv
tb/tb_keyword_byte_substitution.sv
